// ===== sv/pcch_pkg.sv =====
// ============================================================================
// pcch_pkg
// Shared types, call identifiers and helpers for the power call handler.
// ============================================================================
package pcch_pkg;

    // Number of cores in cluster 0 (2..4)
    localparam int CORE_COUNT = 2;
    localparam int CORE_IDX_W = $clog2(CORE_COUNT);
    localparam logic [7:0] CORE_LIMIT = 8'(CORE_COUNT);

    localparam logic [16:0] VERSION_VALUE = 17'h10000;

    localparam logic [31:0] FN_VERSION     = 32'h8400_0000;
    localparam logic [31:0] FN_CPU_OFF     = 32'h8400_0002;
    localparam logic [31:0] FN_CPU_ON      = 32'h8400_0003;
    localparam logic [31:0] FN64_CPU_ON    = 32'hC400_0003;
    localparam logic [31:0] FN_AFF_INFO    = 32'h8400_0004;
    localparam logic [31:0] FN64_AFF_INFO  = 32'hC400_0004;
    localparam logic [31:0] FN_SYS_RESET   = 32'h8400_0009;
    localparam logic [31:0] FN64_SYS_RESET = 32'hC400_0009;
    localparam logic [31:0] FN_FEATURES    = 32'h8400_000A;
    localparam logic [31:0] FN64_FEATURES  = 32'hC400_000A;

    typedef enum logic [2:0] {
        ST_SUCCESS       = 3'd0,
        ST_NOT_SUPPORTED = 3'd1,
        ST_INVALID       = 3'd2,
        ST_DENIED        = 3'd3,
        ST_ALREADY_ON    = 3'd4,
        ST_INTERNAL      = 3'd5,
        ST_VALUE         = 3'd6
    } status_t;

    // Reported core power states
    localparam logic [16:0] PS_ON  = 17'd0;
    localparam logic [16:0] PS_OFF = 17'd1;

    typedef struct packed {
        status_t     status;
        logic [16:0] result_value;
        logic        start_request;
        logic [1:0]  start_core;
        logic [31:0] start_address;
        logic        stop_request;
        logic [1:0]  stop_core;
        logic        reset_request;
    } result_t;

    // Write to the per-core power table
    typedef struct packed {
        logic                  en;
        logic [CORE_IDX_W-1:0] core;
        logic                  on;
    } update_t;

    function automatic status_t feature_status(input logic [31:0] fid);
        status_t st;
        case (fid) inside
            FN_VERSION, FN_FEATURES, FN_AFF_INFO,
            FN_SYS_RESET, FN_CPU_ON, FN_CPU_OFF: st = ST_SUCCESS;
            default:                             st = ST_NOT_SUPPORTED;
        endcase
        return st;
    endfunction

endpackage

// ===== sv/pcch_if.sv =====
// ============================================================================
// pcch_call_if / pcch_answer_if
// Valid/ready channels carrying a call and its answer.
// ============================================================================
interface pcch_call_if;
    logic        valid;
    logic        ready;
    logic [31:0] action;
    logic [31:0] first_argument;
    logic [31:0] second_argument;
    logic [15:0] caller_affinity;

    modport source (output valid, action, first_argument, second_argument,
                    caller_affinity, input ready);
    modport sink   (input valid, action, first_argument, second_argument,
                    caller_affinity, output ready);
endinterface

interface pcch_answer_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [16:0] result_value;
    logic        start_request;
    logic [1:0]  start_core;
    logic [31:0] start_address;
    logic        stop_request;
    logic [1:0]  stop_core;
    logic        reset_request;

    modport source (output valid, status, result_value, start_request, start_core,
                    start_address, stop_request, stop_core, reset_request,
                    input ready);
    modport sink   (input valid, status, result_value, start_request, start_core,
                    start_address, stop_request, stop_core, reset_request,
                    output ready);
endinterface

// ===== sv/pcch_decode.sv =====
// ============================================================================
// pcch_decode
// Call decode: validates arguments against the core power table and forms
// the answer plus the table write for one call.
// ============================================================================
module pcch_decode
    import pcch_pkg::*;
(
    input  logic [31:0]           action,
    input  logic [31:0]           first_argument,
    input  logic [31:0]           second_argument,
    input  logic [15:0]           caller_affinity,
    input  logic [CORE_COUNT-1:0] core_on,
    output result_t               result,
    output update_t               update
);

    logic [7:0] on_cluster;
    logic [7:0] on_core;
    logic [7:0] off_cluster;
    logic [7:0] off_core;
    logic [1:0] aff_core;

    assign on_cluster  = first_argument[15:8];
    assign on_core     = first_argument[7:0];
    assign off_cluster = caller_affinity[15:8];
    assign off_core    = caller_affinity[7:0];
    assign aff_core    = first_argument[1:0];

    always_comb
    begin
        result        = '0;
        result.status = ST_NOT_SUPPORTED;
        update        = '0;

        unique case (action) inside
            FN_VERSION:
            begin
                result.status       = ST_VALUE;
                result.result_value = VERSION_VALUE;
            end
            FN_FEATURES, FN64_FEATURES:
            begin
                result.status = feature_status(first_argument);
            end
            FN_CPU_ON, FN64_CPU_ON:
            begin
                if (on_cluster != 8'd0 || on_core >= CORE_LIMIT || second_argument == 32'd0)
                begin
                    result.status = ST_INVALID;
                end
                else if (on_core == 8'd0 || core_on[on_core[CORE_IDX_W-1:0]])
                begin
                    result.status = ST_ALREADY_ON;
                end
                else
                begin
                    result.status        = ST_SUCCESS;
                    result.start_request = 1'b1;
                    result.start_core    = on_core[1:0];
                    result.start_address = second_argument;
                    update.en            = 1'b1;
                    update.core          = on_core[CORE_IDX_W-1:0];
                    update.on            = 1'b1;
                end
            end
            FN_CPU_OFF:
            begin
                if (off_cluster != 8'd0 || off_core >= CORE_LIMIT)
                begin
                    result.status = ST_INVALID;
                end
                else if (off_core == 8'd0)
                begin
                    result.status = ST_DENIED;
                end
                else
                begin
                    result.status       = ST_SUCCESS;
                    result.stop_request = 1'b1;
                    result.stop_core    = off_core[1:0];
                    update.en           = 1'b1;
                    update.core         = off_core[CORE_IDX_W-1:0];
                    update.on           = 1'b0;
                end
            end
            FN_AFF_INFO, FN64_AFF_INFO:
            begin
                if (second_argument != 32'd0 || {6'd0, aff_core} >= CORE_LIMIT)
                begin
                    result.status = ST_INVALID;
                end
                else
                begin
                    result.status       = ST_VALUE;
                    result.result_value = core_on[aff_core[CORE_IDX_W-1:0]] ? PS_ON : PS_OFF;
                end
            end
            FN_SYS_RESET, FN64_SYS_RESET:
            begin
                result.status        = ST_INTERNAL;
                result.reset_request = 1'b1;
            end
            default:
            begin
                result.status = ST_NOT_SUPPORTED;
            end
        endcase
    end

endmodule

// ===== sv/power_coordination_call_handler.sv =====
// ============================================================================
// power_coordination_call_handler
// Power-coordination call dispatcher with a per-core on/off table.
// ============================================================================
// Path: call register, decode, answer register; a stalled answer can hold
// the call in the call register before its answer is registered.
// Throughput: one call per cycle while the answer is not stalled; the table
// write and read sit in the same stage, so back-to-back calls see each other's
// updates. Holds two calls while the answer stalls, then drops call ready.
// Reset: core 0 on, other cores off; both stage valids cleared.
module power_coordination_call_handler
    import pcch_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pcch_call_if.sink     call,
    pcch_answer_if.source answer
);

    logic                  call_valid_reg;
    logic [31:0]           action_reg;
    logic [31:0]           first_argument_reg;
    logic [31:0]           second_argument_reg;
    logic [15:0]           caller_affinity_reg;
    logic [CORE_COUNT-1:0] core_on_reg;
    logic [CORE_COUNT-1:0] core_on_next;
    logic                  answer_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    update_t               update;
    logic                  advance;

    assign advance    = call_valid_reg && (!answer_valid_reg || answer.ready);
    assign call.ready = !call_valid_reg || advance;

    pcch_decode u_decode (
        .action          (action_reg),
        .first_argument  (first_argument_reg),
        .second_argument (second_argument_reg),
        .caller_affinity (caller_affinity_reg),
        .core_on         (core_on_reg),
        .result          (result_next),
        .update          (update)
    );

    always_comb
    begin
        core_on_next = core_on_reg;
        if (update.en)
        begin
            core_on_next[update.core] = update.on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_valid_reg   <= 1'b0;
            answer_valid_reg <= 1'b0;
            core_on_reg      <= CORE_COUNT'(1);
        end
        else
        begin
            if (call.ready)
            begin
                call_valid_reg <= call.valid;
            end
            if (advance)
            begin
                answer_valid_reg <= 1'b1;
                core_on_reg      <= core_on_next;
            end
            else if (answer.ready)
            begin
                answer_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (call.valid && call.ready)
        begin
            action_reg          <= call.action;
            first_argument_reg  <= call.first_argument;
            second_argument_reg <= call.second_argument;
            caller_affinity_reg <= call.caller_affinity;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign answer.valid         = answer_valid_reg;
    assign answer.status        = result_reg.status;
    assign answer.result_value  = result_reg.result_value;
    assign answer.start_request = result_reg.start_request;
    assign answer.start_core    = result_reg.start_core;
    assign answer.start_address = result_reg.start_address;
    assign answer.stop_request  = result_reg.stop_request;
    assign answer.stop_core     = result_reg.stop_core;
    assign answer.reset_request = result_reg.reset_request;

endmodule
